@@ rtl/core/mtts_pkg.sv @@
// Shared package of the multi-track trigger sequencer.
// Holds sizes, codes, output levels and the lane control and status types.
// No dependencies.
`timescale 1ns / 1ps

package mtts_pkg;

  localparam int TRACKS = 8;
  localparam int STEPS  = 16;
  localparam int TRACK_W = $clog2(TRACKS);
  localparam int STEP_W  = $clog2(STEPS);
  localparam int COL_W   = $clog2(STEPS + 1);

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_CELL  = 2'd1,
    REQ_RESET = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    CFG_LOOP_ENABLE = 3'd0,
    CFG_PROB_A      = 3'd1,
    CFG_PROB_B      = 3'd2,
    CFG_SKIP_A      = 3'd3,
    CFG_SKIP_B      = 3'd4,
    CFG_DIVISIONS   = 3'd5,
    CFG_GATE_MODES  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LEVEL_LOW   = 2'd0,
    LEVEL_HIGH  = 2'd1,
    LEVEL_ERROR = 2'd2
  } level_e;

  localparam logic [3:0] CELL_LOW      = 4'd0;
  localparam logic [3:0] CELL_HIGH     = 4'd1;
  localparam logic [3:0] CELL_PROB_A   = 4'd2;
  localparam logic [3:0] CELL_PROB_B   = 4'd3;
  localparam logic [3:0] CELL_RARE_A   = 4'd4;
  localparam logic [3:0] CELL_NRARE_A  = 4'd5;
  localparam logic [3:0] CELL_RARE_B   = 4'd6;
  localparam logic [3:0] CELL_NRARE_B  = 4'd7;
  localparam logic [3:0] CELL_BOTH_A   = 4'd8;
  localparam logic [3:0] CELL_BOTH_B   = 4'd9;
  localparam logic [3:0] CELL_RESTART  = 4'd10;

  typedef struct packed {
    logic             tick;
    logic             glob_rst;
    logic             loop_en;
    logic [8:0]       prob_a;
    logic [8:0]       prob_b;
    logic [4:0]       skip_a;
    logic [4:0]       skip_b;
    logic [STEP_W-1:0] cell_step;
    logic [3:0]       cell_value;
  } lane_ctl_t;

  typedef struct packed {
    level_e           level;
    logic [COL_W-1:0] step;
  } lane_stat_t;

endpackage

@@ rtl/core/mtts_lane.sv @@
// One track of the sequencer: grid row, divider, step column and rarity counters.
// Computes its whole next state for one word combinationally and registers it.
// Depends on mtts_pkg.
`timescale 1ns / 1ps

module mtts_lane (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mtts_pkg::lane_ctl_t    ctl_i,
  input  logic                   cell_we_i,
  input  logic [3:0]             init_cell0_i,
  input  logic                   clk_now_i,
  input  logic                   clk_was_i,
  input  logic                   rst_now_i,
  input  logic                   rst_was_i,
  input  logic [7:0]             rnd_i,
  input  logic [3:0]             div_i,
  input  logic                   gate_hold_i,
  output mtts_pkg::lane_stat_t   stat_o
);

  // Entry zero is stored relative to its reset code, so every grid entry resets to zero.
  logic [3:0]                  row_q [mtts_pkg::STEPS];
  logic [mtts_pkg::COL_W-1:0]  step_q, step_d;
  logic [3:0]                  dcnt_q, dcnt_d;
  logic [4:0]                  ra_q, ra_d, rb_q, rb_d;
  logic                        pend_q, pend_d;
  mtts_pkg::level_e            level_q, level_d;

  logic [mtts_pkg::COL_W-1:0]  stop_col;
  logic [3:0]                  row0;
  logic [3:0]                  c1, c2;
  logic [5:0]                  a6, b6;
  logic [4:0]                  n5;

  function automatic mtts_pkg::level_e cell_level(input logic [3:0] code, input logic ra,
                                                  input logic rb, input logic pa,
                                                  input logic pb);
    logic hit;
    logic err;
    hit = 1'b0;
    err = 1'b0;
    case (code)
      mtts_pkg::CELL_LOW:     hit = 1'b0;
      mtts_pkg::CELL_HIGH:    hit = 1'b1;
      mtts_pkg::CELL_PROB_A:  hit = pa;
      mtts_pkg::CELL_PROB_B:  hit = pb;
      mtts_pkg::CELL_RARE_A:  hit = ra;
      mtts_pkg::CELL_NRARE_A: hit = !ra;
      mtts_pkg::CELL_RARE_B:  hit = rb;
      mtts_pkg::CELL_NRARE_B: hit = !rb;
      mtts_pkg::CELL_BOTH_A:  hit = ra && pa;
      mtts_pkg::CELL_BOTH_B:  hit = rb && pb;
      default:                err = 1'b1;
    endcase
    if (err) begin
      return mtts_pkg::LEVEL_ERROR;
    end
    return hit ? mtts_pkg::LEVEL_HIGH : mtts_pkg::LEVEL_LOW;
  endfunction

  assign stop_col = ctl_i.loop_en ? '0 : mtts_pkg::COL_W'(mtts_pkg::STEPS);
  assign row0     = row_q[0] ^ init_cell0_i;

  always_comb begin
    step_d  = step_q;
    dcnt_d  = dcnt_q;
    ra_d    = ra_q;
    rb_d    = rb_q;
    pend_d  = pend_q;
    level_d = level_q;
    a6      = '0;
    b6      = '0;
    n5      = '0;
    c1      = mtts_pkg::CELL_LOW;
    c2      = mtts_pkg::CELL_LOW;

    if (ctl_i.glob_rst || (ctl_i.tick && rst_now_i && !rst_was_i)) begin
      step_d = '0;
      dcnt_d = '0;
      ra_d   = 5'd1;
      rb_d   = 5'd1;
      pend_d = 1'b1;
    end

    if (ctl_i.tick) begin
      if (!clk_now_i && clk_was_i) begin
        if (!gate_hold_i && dcnt_d >= div_i) begin
          level_d = mtts_pkg::LEVEL_LOW;
        end
      end else if (clk_now_i && !clk_was_i) begin
        if (step_d == '0) begin
          a6   = {1'b0, ra_d} + 6'd1;
          b6   = {1'b0, rb_d} + 6'd1;
          ra_d = (a6 > {1'b0, ctl_i.skip_a}) ? 5'd1 : a6[4:0];
          rb_d = (b6 > {1'b0, ctl_i.skip_b}) ? 5'd1 : b6[4:0];
        end
        if (pend_d) begin
          pend_d = 1'b0;
        end else begin
          n5 = {1'b0, dcnt_d} + 5'd1;
          if (n5 >= {1'b0, div_i} + 5'd1) begin
            dcnt_d = '0;
            if (step_d >= mtts_pkg::COL_W'(mtts_pkg::STEPS - 1)) begin
              step_d = stop_col;
            end else begin
              step_d = step_d + 1'b1;
            end
          end else begin
            dcnt_d = n5[3:0];
          end
        end
        if (dcnt_d == '0) begin
          if (step_d >= mtts_pkg::COL_W'(mtts_pkg::STEPS)) begin
            c1 = mtts_pkg::CELL_LOW;
          end else if (step_d == '0) begin
            c1 = row0;
          end else begin
            c1 = row_q[step_d[mtts_pkg::STEP_W-1:0]];
          end
          if (c1 == mtts_pkg::CELL_RESTART) begin
            step_d = stop_col;
            c2     = ctl_i.loop_en ? row0 : mtts_pkg::CELL_LOW;
          end else begin
            c2 = c1;
          end
          level_d = cell_level(c2, ra_d == ctl_i.skip_a, rb_d == ctl_i.skip_b,
                               {1'b0, rnd_i} < ctl_i.prob_a,
                               {1'b0, rnd_i} < ctl_i.prob_b);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      dcnt_q  <= '0;
      ra_q    <= 5'd1;
      rb_q    <= 5'd1;
      pend_q  <= 1'b0;
      level_q <= mtts_pkg::LEVEL_LOW;
      for (int i = 0; i < mtts_pkg::STEPS; i++) begin
        row_q[i] <= '0;
      end
    end else begin
      step_q  <= step_d;
      dcnt_q  <= dcnt_d;
      ra_q    <= ra_d;
      rb_q    <= rb_d;
      pend_q  <= pend_d;
      level_q <= level_d;
      if (cell_we_i) begin
        if (ctl_i.cell_step == '0) begin
          row_q[0] <= ctl_i.cell_value ^ init_cell0_i;
        end else begin
          row_q[ctl_i.cell_step] <= ctl_i.cell_value;
        end
      end
    end
  end

  // The merging stage captures the level that this word produces.
  assign stat_o.level = level_d;
  assign stat_o.step  = step_q;

endmodule

@@ rtl/core/mtts_merge.sv @@
// Merging stage: folds the lane levels into trigger and error masks
// and holds them in a two-word output buffer. Depends on mtts_pkg.
`timescale 1ns / 1ps

module mtts_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  mtts_pkg::level_e             levels_i [mtts_pkg::TRACKS],
  input  logic                         out_stall_i,
  output logic                         full_o,
  output logic                         out_valid_o,
  output logic [mtts_pkg::TRACKS-1:0]  track_high_o,
  output logic [mtts_pkg::TRACKS-1:0]  track_error_o
);

  typedef struct packed {
    logic [mtts_pkg::TRACKS-1:0] high;
    logic [mtts_pkg::TRACKS-1:0] err;
  } entry_t;

  entry_t     new_w;
  entry_t     e0_q, e0_d, e1_q, e1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  always_comb begin
    for (int t = 0; t < mtts_pkg::TRACKS; t++) begin
      new_w.high[t] = (levels_i[t] == mtts_pkg::LEVEL_HIGH);
      new_w.err[t]  = (levels_i[t] == mtts_pkg::LEVEL_ERROR);
    end
  end

  assign pop = (cnt_q != 2'd0) && !out_stall_i;

  always_comb begin
    e0_d  = e0_q;
    e1_d  = e1_q;
    cnt_d = cnt_q;
    if (pop) begin
      e0_d = e1_q;
    end
    if (push_i) begin
      if ((cnt_q == 2'd0) || (cnt_q == 2'd1 && pop)) begin
        e0_d = new_w;
      end else begin
        e1_d = new_w;
      end
    end
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  assign full_o        = (cnt_q == 2'd2);
  assign out_valid_o   = (cnt_q != 2'd0);
  assign track_high_o  = e0_q.high;
  assign track_error_o = e0_q.err;

endmodule

@@ rtl/core/multi_track_trigger_sequencer_top.sv @@
// Top level of the multi-track trigger sequencer: configuration registers,
// edge history, one lane per track and the merging stage.
// Depends on mtts_pkg, mtts_lane and mtts_merge.
//
// Channel  Direction  Handshake               Contents
// in       input      in_valid_i / in_stall_o  request type, levels, bytes, cell write
// out      output     out_valid_o / out_stall_i trigger and error masks
// cfg      input      cfg_valid_i / cfg_ready_o register index and data
//
// Every track is updated in parallel in the cycle a word is accepted, so one word is
// taken per cycle while input is not stalled; its result is registered in the
// two-word output buffer, which lets input flow while one result waits; input stalls
// only when both words are held. Reset is asynchronous and restores all registers
// but the buffer's data words, grid included. Configuration writes are never stalled.
`timescale 1ns / 1ps

module multi_track_trigger_sequencer_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   req_type_i,
  input  logic [7:0]   clock_levels_i,
  input  logic [7:0]   reset_levels_i,
  input  logic [63:0]  random_bytes_i,
  input  logic [2:0]   cell_track_i,
  input  logic [3:0]   cell_step_i,
  input  logic [3:0]   cell_value_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [7:0]   track_high_o,
  output logic [7:0]   track_error_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic        loop_q;
  logic [8:0]  prob_a_q, prob_b_q;
  logic [4:0]  skip_a_q, skip_b_q;
  logic [31:0] div_q;
  logic [7:0]  gate_q;
  logic [7:0]  prev_clk_q, prev_rst_q;

  logic                   accept;
  logic                   full;
  mtts_pkg::lane_ctl_t    ctl;
  mtts_pkg::lane_stat_t   stat [mtts_pkg::TRACKS];
  mtts_pkg::level_e       levels [mtts_pkg::TRACKS];
  logic                   all_step_zero;
  logic                   all_step_ok;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q   <= 1'b1;
      prob_a_q <= 9'd230;
      prob_b_q <= 9'd128;
      skip_a_q <= 5'd2;
      skip_b_q <= 5'd4;
      div_q    <= 32'd2004318071;
      gate_q   <= 8'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mtts_pkg::CFG_LOOP_ENABLE: loop_q   <= cfg_data_i[0];
        mtts_pkg::CFG_PROB_A:      prob_a_q <= cfg_data_i[8:0];
        mtts_pkg::CFG_PROB_B:      prob_b_q <= cfg_data_i[8:0];
        mtts_pkg::CFG_SKIP_A:      skip_a_q <= cfg_data_i[4:0];
        mtts_pkg::CFG_SKIP_B:      skip_b_q <= cfg_data_i[4:0];
        mtts_pkg::CFG_DIVISIONS:   div_q    <= cfg_data_i;
        mtts_pkg::CFG_GATE_MODES:  gate_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_clk_q <= '0;
      prev_rst_q <= '0;
    end else if (accept && req_type_i == mtts_pkg::REQ_TICK) begin
      prev_clk_q <= clock_levels_i;
      prev_rst_q <= reset_levels_i;
    end
  end

  always_comb begin
    ctl.tick       = accept && (req_type_i == mtts_pkg::REQ_TICK);
    ctl.glob_rst   = accept && (req_type_i == mtts_pkg::REQ_RESET);
    ctl.loop_en    = loop_q;
    ctl.prob_a     = prob_a_q;
    ctl.prob_b     = prob_b_q;
    ctl.skip_a     = skip_a_q;
    ctl.skip_b     = skip_b_q;
    ctl.cell_step  = cell_step_i;
    ctl.cell_value = cell_value_i;
  end

  for (genvar t = 0; t < mtts_pkg::TRACKS; t++) begin : g_lane
    mtts_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .cell_we_i    (accept && (req_type_i == mtts_pkg::REQ_CELL) &&
                     (cell_track_i == mtts_pkg::TRACK_W'(t))),
      .init_cell0_i ((t == 0) ? mtts_pkg::CELL_HIGH : mtts_pkg::CELL_LOW),
      .clk_now_i    (clock_levels_i[t]),
      .clk_was_i    (prev_clk_q[t]),
      .rst_now_i    (reset_levels_i[t]),
      .rst_was_i    (prev_rst_q[t]),
      .rnd_i        (random_bytes_i[8*t +: 8]),
      .div_i        (div_q[4*t +: 4]),
      .gate_hold_i  (gate_q[t]),
      .stat_o       (stat[t])
    );
    assign levels[t] = stat[t].level;
  end

  mtts_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (accept),
    .levels_i      (levels),
    .out_stall_i   (out_stall_i),
    .full_o        (full),
    .out_valid_o   (out_valid_o),
    .track_high_o  (track_high_o),
    .track_error_o (track_error_o)
  );

  always_comb begin
    all_step_zero = 1'b1;
    all_step_ok   = 1'b1;
    for (int t = 0; t < mtts_pkg::TRACKS; t++) begin
      all_step_zero &= (stat[t].step == '0);
      all_step_ok   &= (stat[t].step <= mtts_pkg::COL_W'(mtts_pkg::STEPS));
    end
  end

  a_glob_reset_clears_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == mtts_pkg::REQ_RESET) |=> all_step_zero)
    else $error("global reset did not return every track to step zero");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    all_step_ok)
    else $error("step column beyond the stopped position");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word produced no result");

  a_full_holds_under_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && out_stall_i) |=> in_stall_o)
    else $error("output buffer lost a word while stalled");

endmodule
